// ===== src/fk3_pkg.sv =====
// shared types, constants and the arctangent table for the three-link kinematics block
`default_nettype none
package fk3_pkg;

	localparam int ANG_W = 16;
	localparam int LEN_W = 14;
	localparam int BASE_W = 16;
	localparam int PT_W = 18;
	localparam int SUM_W = 18;
	localparam int CORD_W = 34;
	localparam int TRIG_W = 32;
	localparam int PROD_W = 47;
	localparam int ACC_W = 49;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ATAN_LEN = 24;

	localparam logic [CFG_IDX_W-1:0] REG_LINK1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINK2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 3'd4;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam logic [CORD_W-1:0] GAIN_Q30 = 34'd652032874;

	localparam logic signed [CORD_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043836, 34'sd133525158,
		34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
		34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
		34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
		34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
		34'sd1023,      34'sd511,       34'sd255,       34'sd127
	};

	typedef struct packed {
		logic signed [PROD_W-1:0] px;
		logic signed [PROD_W-1:0] py;
	} lane_prod_t;

	typedef struct packed {
		logic [PT_W-1:0] elbow_x;
		logic [PT_W-1:0] elbow_y;
		logic [PT_W-1:0] wrist_x;
		logic [PT_W-1:0] wrist_y;
		logic [PT_W-1:0] tip_x;
		logic [PT_W-1:0] tip_y;
	} points_t;

endpackage
`default_nettype wire

// ===== src/fk3_lane.sv =====
// one link lane: angle wrap, quadrant split, radian scaling, pipelined cordic, length product
`default_nettype none
module fk3_lane import fk3_pkg::*; #(
	parameter int STAGES = 16
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [SUM_W-1:0] ang,
	input  wire logic [LEN_W-1:0]        len,
	output lane_prod_t                   prod
);

	logic [15:0] m_s1;
	logic [13:0] r_s2;
	logic [1:0]  q_s2;
	logic [40:0] pa_s3;
	logic [13:0] q45_s3;
	logic [1:0]  q_s3;

	logic signed [CORD_W-1:0] x_s [STAGES+1];
	logic signed [CORD_W-1:0] y_s [STAGES+1];
	logic signed [CORD_W-1:0] z_s [STAGES+1];
	logic [1:0]               q_s [STAGES+1];

	logic [17:0] wrap;
	logic [13:0] rem;
	logic [1:0]  quad;
	logic [18:0] xr;
	logic signed [TRIG_W-1:0] c_v;
	logic signed [TRIG_W-1:0] s_v;

	// wrap into 0..46079 by offsetting three turns then peeling 4, 2, 1 turns
	always_comb begin
		logic [18:0] t;
		t = 19'(ang) + 19'sd138240;
		wrap = t[17:0];
		if (wrap >= 18'd184320) wrap = wrap - 18'd184320;
		if (wrap >= 18'd92160) wrap = wrap - 18'd92160;
		if (wrap >= 18'd46080) wrap = wrap - 18'd46080;
	end

	always_comb begin
		if (m_s1 >= 16'd34560) begin
			quad = QUAD_3;
			rem = 14'(m_s1 - 16'd34560);
		end else if (m_s1 >= 16'd23040) begin
			quad = QUAD_2;
			rem = 14'(m_s1 - 16'd23040);
		end else if (m_s1 >= 16'd11520) begin
			quad = QUAD_1;
			rem = 14'(m_s1 - 16'd11520);
		end else begin
			quad = QUAD_0;
			rem = 14'(m_s1);
		end
	end

	// pi*r/23040 in q30: r*74961320 + floor((26r + 11520)/45), all over 512
	assign xr = 19'(r_s2) * 19'd26 + 19'd11520;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= 16'(wrap);
			r_s2 <= rem;
			q_s2 <= quad;
			pa_s3 <= 41'(r_s2) * 41'd74961320;
			q45_s3 <= 14'((39'(xr) * 39'd745655) >> 25);
			q_s3 <= q_s2;
			z_s[0] <= CORD_W'((pa_s3 + 41'(q45_s3)) >> 9);
			q_s[0] <= q_s3;
		end
	end

	assign x_s[0] = GAIN_Q30;
	assign y_s[0] = '0;

	for (genvar i = 0; i < STAGES; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CORD_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_Q30[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_Q30[i];
				end
				q_s[i+1] <= q_s[i];
			end
		end
	end

	always_comb begin
		case (q_s[STAGES])
			QUAD_0: begin
				c_v = TRIG_W'(x_s[STAGES]);
				s_v = TRIG_W'(y_s[STAGES]);
			end
			QUAD_1: begin
				c_v = -TRIG_W'(y_s[STAGES]);
				s_v = TRIG_W'(x_s[STAGES]);
			end
			QUAD_2: begin
				c_v = -TRIG_W'(x_s[STAGES]);
				s_v = -TRIG_W'(y_s[STAGES]);
			end
			default: begin
				c_v = TRIG_W'(y_s[STAGES]);
				s_v = -TRIG_W'(x_s[STAGES]);
			end
		endcase
	end

	// operands widened to the full product width before the multiply
	always_ff @(posedge clk) begin
		if (en) begin
			prod.px <= PROD_W'($signed({1'b0, len})) * PROD_W'(c_v);
			prod.py <= PROD_W'($signed({1'b0, len})) * PROD_W'(s_v);
		end
	end

endmodule
`default_nettype wire

// ===== src/fk3_merge.sv =====
// chains the three link vectors onto the base point and rounds to sixteenths of a pixel
`default_nettype none
module fk3_merge import fk3_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [BASE_W-1:0] base_x,
	input  wire logic [BASE_W-1:0] base_y,
	input  wire lane_prod_t        prod [3],
	output points_t                pts
);

	logic signed [ACC_W-1:0] bx;
	logic signed [ACC_W-1:0] by;
	logic signed [ACC_W-1:0] ex_s1, ey_s1, p2x_s1, p2y_s1, p23x_s1, p23y_s1;
	logic signed [ACC_W-1:0] ex_s2, ey_s2, wx_s2, wy_s2, tx_s2, ty_s2;

	assign bx = {3'b0, base_x, 30'b0};
	assign by = {3'b0, base_y, 30'b0};

	// add half an lsb, keep bits 30 to 47
	function automatic logic [PT_W-1:0] round_pt(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = v + 49'sd536870912;
		return t[47:30];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1 <= bx + ACC_W'(prod[0].px);
			ey_s1 <= by - ACC_W'(prod[0].py);
			p2x_s1 <= ACC_W'(prod[1].px);
			p2y_s1 <= ACC_W'(prod[1].py);
			p23x_s1 <= ACC_W'(prod[1].px) + ACC_W'(prod[2].px);
			p23y_s1 <= ACC_W'(prod[1].py) + ACC_W'(prod[2].py);
			ex_s2 <= ex_s1;
			ey_s2 <= ey_s1;
			wx_s2 <= ex_s1 + p2x_s1;
			wy_s2 <= ey_s1 - p2y_s1;
			tx_s2 <= ex_s1 + p23x_s1;
			ty_s2 <= ey_s1 - p23y_s1;
			pts.elbow_x <= round_pt(ex_s2);
			pts.elbow_y <= round_pt(ey_s2);
			pts.wrist_x <= round_pt(wx_s2);
			pts.wrist_y <= round_pt(wy_s2);
			pts.tip_x <= round_pt(tx_s2);
			pts.tip_y <= round_pt(ty_s2);
		end
	end

endmodule
`default_nettype wire

// ===== src/planar_three_link_forward_kinematics.sv =====
// top level of the planar three-link forward kinematics pipeline
//
// channel   dir  width  content
// s_axis    in   48     joint angles, 1/128 degree
// m_axis    out  112    elbow, wrist, tip points, 1/16 pixel
// cfg       in   16     link lengths and base point
//
// one beat per cycle in and out unless m_axis stalls; the pipeline registers sit in
// the angle sum and prep (5), the cordic stages, the length product and the merge (3)
// reset clears the config registers to their defaults and empties the pipeline
// the whole pipeline holds while a result sits on m_axis unaccepted
`default_nettype none
module planar_three_link_forward_kinematics import fk3_pkg::*; #(
	parameter int SINCOS_STAGES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// joint1_angle[15:0], joint2_angle[31:16], joint3_angle[47:32]
	input  wire logic [47:0]           s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// elbow_x[17:0], elbow_y[35:18], wrist_x[53:36], wrist_y[71:54],
	// tip_x[89:72], tip_y[107:90], zero pad [111:108]
	output logic [111:0]               m_axis_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LAT = SINCOS_STAGES + 9;

	logic [LEN_W-1:0]  link1_q, link2_q, link3_q;
	logic [BASE_W-1:0] base_x_q, base_y_q;
	logic [LAT-1:0]    vld_q;
	logic              en;
	logic signed [SUM_W-1:0] a1_s1, a2_s1, a3_s1;
	logic signed [SUM_W-1:0] j1, j2, j3;
	lane_prod_t        prod [3];
	points_t           pts;

	// config registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link1_q <= 14'd1600;
			link2_q <= 14'd1600;
			link3_q <= 14'd1600;
			base_x_q <= 16'd3200;
			base_y_q <= 16'd3200;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINK1: link1_q <= cfg_data[LEN_W-1:0];
				REG_LINK2: link2_q <= cfg_data[LEN_W-1:0];
				REG_LINK3: link3_q <= cfg_data[LEN_W-1:0];
				REG_BASE_X: base_x_q <= cfg_data;
				REG_BASE_Y: base_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: move whenever the output slot is free or being drained
	assign en = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	assign j1 = SUM_W'($signed(s_axis_tdata[15:0]));
	assign j2 = SUM_W'($signed(s_axis_tdata[31:16]));
	assign j3 = SUM_W'($signed(s_axis_tdata[47:32]));

	// absolute link angles, still unwrapped
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1 <= j1;
			a2_s1 <= j1 + j2;
			a3_s1 <= j1 + j2 + j3;
		end
	end

	fk3_lane #(.STAGES(SINCOS_STAGES)) u_lane1 (
		.clk(clk), .en(en), .ang(a1_s1), .len(link1_q), .prod(prod[0])
	);
	fk3_lane #(.STAGES(SINCOS_STAGES)) u_lane2 (
		.clk(clk), .en(en), .ang(a2_s1), .len(link2_q), .prod(prod[1])
	);
	fk3_lane #(.STAGES(SINCOS_STAGES)) u_lane3 (
		.clk(clk), .en(en), .ang(a3_s1), .len(link3_q), .prod(prod[2])
	);

	fk3_merge u_merge (
		.clk(clk), .en(en), .base_x(base_x_q), .base_y(base_y_q),
		.prod(prod), .pts(pts)
	);

	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tdata = {4'b0, pts.tip_y, pts.tip_x, pts.wrist_y, pts.wrist_x,
		pts.elbow_y, pts.elbow_x};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_busy_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input refused with empty output slot");

	a_drain_frees: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |-> s_axis_tready)
		else $error("pipeline held while output drained");

endmodule
`default_nettype wire
